// File: hw/rtl/smpt_pkg.sv
// ----------------------------------------------------------------------------
// Silhouette mask point test package
// Shared constants, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package smpt_pkg;

  localparam int IMAGE_SIZE = 1024;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = 24;
  localparam int ROOT_W     = 12;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;
  localparam int IDX_W      = $clog2(IMAGE_SIZE);
  localparam int MEM_DEPTH  = IMAGE_SIZE * IMAGE_SIZE;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int RAD_W      = 2 * COORD_W;
  localparam int SQRT_STEPS = COORD_W;
  localparam int DIV_W      = COORD_W + SCALE_FRAC;
  localparam int DEN_W      = SCALE_W + 1;
  localparam int REM_W      = DEN_W;
  localparam int POS_W      = DIV_W + ROOT_W - 8;
  localparam int CNT_W      = $clog2(DIV_W);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] PROJ_DIRECT = 2'd0;
  localparam logic [1:0] PROJ_REV    = 2'd1;
  localparam logic [1:0] PROJ_ORTHO  = 2'd2;

  typedef enum logic [1:0] {
    CFG_ROOT_COL    = 2'd0,
    CFG_ROOT_ROW    = 2'd1,
    CFG_SCALE       = 2'd2,
    CFG_MASK_LOADED = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ_INIT,
    ST_SQRT,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_END,
    ST_PROBE_ADDR,
    ST_PROBE_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       res_set;
    logic       res_clr;
    logic       res_or;
    logic       out_load;
    logic       mul;
    logic       sq_init;
    logic       sq_step;
    logic       div_start;
    logic       div_step;
    logic       pos_store;
    logic       axis;
    logic       rd;
    logic [1:0] off_c;
    logic [1:0] off_r;
  } cmd_t;

  typedef struct packed {
    logic no_mask;
    logic scale_zero;
    logic nb_ok;
  } sts_t;

endpackage

// File: hw/rtl/silhouette_mask_point_test.sv
// ----------------------------------------------------------------------------
// Silhouette mask point test
// A query in direct mode only reads the mask; orthographic mode adds the
// 32-step divider run once per axis, and revolution mode adds before it the
// 24-step square root. Every mode ends in up to nine reads of the
// single-port mask memory.
// One word is in work at a time. Reset clears control and configuration;
// the mask memory is not cleared and holds nothing valid until written.
// ----------------------------------------------------------------------------
module silhouette_mask_point_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                kind,
  input  logic [1:0]                          projection,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_y,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_z,
  input  logic [9:0]                          write_col,
  input  logic [9:0]                          write_row,
  input  logic [23:0]                         pixel_color,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                inside_res,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [smpt_pkg::SCALE_W-1:0]        cfg_data
);
  import smpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .projection (projection),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  smpt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .projection  (projection),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .write_col   (write_col),
    .write_row   (write_row),
    .pixel_color (pixel_color),
    .cmd         (cmd),
    .sts         (sts),
    .inside_res  (inside_res)
  );

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> sts.nb_ok)
    else $error("mask read issued for a pixel outside the image");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd && cmd.wr))
    else $error("mask read and write in the same cycle");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res_valid || !res_stall))
    else $error("result loaded over a word still waiting");

  a_res_or_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.res_or |-> $past(cmd.rd))
    else $error("mask data taken without a read");

endmodule

// File: hw/rtl/smpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module smpt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/smpt_ctrl.sv
// ----------------------------------------------------------------------------
// Silhouette mask point test controller
// Sequences the square root, the two divisions and the up to nine mask reads
// of a query as its mode needs, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module smpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic          kind,
  input  logic [1:0]    projection,
  output logic          res_valid,
  input  logic          res_stall,
  input  smpt_pkg::sts_t sts,
  output smpt_pkg::cmd_t cmd
);
  import smpt_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             axis, axis_next;
  logic [1:0]       off_c, off_c_next;
  logic [1:0]       off_r, off_r_next;
  logic             res_valid_next;
  logic             accept;
  logic             step_nb;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid & ~req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      axis      <= 1'b0;
      off_c     <= '0;
      off_r     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      axis      <= axis_next;
      off_c     <= off_c_next;
      off_r     <= off_r_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    off_c_next = off_c;
    off_r_next = off_r;
    step_nb    = 1'b0;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.off_c  = off_c;
    cmd.off_r  = off_r;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          axis_next  = 1'b0;
          off_c_next = '0;
          off_r_next = '0;
          if (kind == KIND_WRITE) begin
            cmd.wr = 1'b1;
          end else if (sts.no_mask) begin
            cmd.res_set = 1'b1;
            state_next  = ST_DONE;
          end else begin
            cmd.res_clr = 1'b1;
            if ((projection == PROJ_REV || projection == PROJ_ORTHO) && sts.scale_zero) begin
              state_next = ST_DONE;
            end else if (projection == PROJ_REV) begin
              state_next = ST_MUL;
            end else if (projection == PROJ_ORTHO) begin
              state_next = ST_DIV_START;
            end else begin
              state_next = ST_PROBE_ADDR;
            end
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        cnt_next    = CNT_W'(SQRT_STEPS - 1);
        state_next  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DIV_START;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        cnt_next      = CNT_W'(DIV_W - 1);
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DIV_END;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_DIV_END: begin
        cmd.pos_store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = ST_DIV_START;
        end else begin
          state_next = ST_PROBE_ADDR;
        end
      end
      ST_PROBE_ADDR: begin
        if (sts.nb_ok) begin
          cmd.rd     = 1'b1;
          state_next = ST_PROBE_DATA;
        end else begin
          step_nb = 1'b1;
        end
      end
      ST_PROBE_DATA: begin
        cmd.res_or = 1'b1;
        step_nb    = 1'b1;
        state_next = ST_PROBE_ADDR;
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (step_nb) begin
      if (off_c == 2'd2) begin
        off_c_next = '0;
        if (off_r == 2'd2) begin
          state_next = ST_DONE;
        end else begin
          off_r_next = off_r + 2'd1;
          state_next = ST_PROBE_ADDR;
        end
      end else begin
        off_c_next = off_c + 2'd1;
        state_next = ST_PROBE_ADDR;
      end
    end

    res_valid_next = cmd.out_load | (res_valid & res_stall);
  end

endmodule

// File: hw/rtl/smpt_dp.sv
// ----------------------------------------------------------------------------
// Silhouette mask point test datapath
// Configuration registers, squaring, bit-serial square root, shared restoring
// divider, neighborhood addressing and the mask memory.
// ----------------------------------------------------------------------------
module smpt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [smpt_pkg::SCALE_W-1:0]        cfg_data,
  input  logic [1:0]                          projection,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_y,
  input  logic signed [smpt_pkg::COORD_W-1:0] coord_z,
  input  logic [9:0]                          write_col,
  input  logic [9:0]                          write_row,
  input  logic [23:0]                         pixel_color,
  input  smpt_pkg::cmd_t                      cmd,
  output smpt_pkg::sts_t                      sts,
  output logic                                inside_res
);
  import smpt_pkg::*;

  logic signed [ROOT_W-1:0]  root_col, root_row;
  logic [SCALE_W-1:0]        scale;
  logic                      mask_loaded;

  logic [1:0]                proj_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic signed [RAD_W-1:0]   prod_x, prod_y;
  logic [RAD_W-1:0]          xx, yy, rad, sq_res, sq_bit, trial;

  logic [DIV_W-1:0]          quo, dividend;
  logic [REM_W-1:0]          rem;
  logic [DEN_W-1:0]          den, den_start;
  logic                      neg, neg_start, rnd;
  logic [REM_W:0]            div_t;

  logic signed [COORD_W-1:0] ax, t_fl, t_tr;
  logic signed [COORD_W:0]   n_o, zmag;
  logic signed [DIV_W:0]     num, num_mag;

  logic signed [POS_W-1:0]   pos_c, pos_r, q_mag, q_s, root_ax, pos_new;
  logic signed [POS_W-1:0]   nb_c, nb_r;
  logic                      nb_ok, wr_ok, res, rdata, ram_we;
  logic [ADDR_W-1:0]         nb_addr, wr_addr, ram_addr;

  function automatic logic signed [1:0] off_val(input logic [1:0] off);
    logic signed [1:0] v;
    case (off)
      2'd0:    v = -2'sd1;
      2'd1:    v = 2'sd0;
      default: v = 2'sd1;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      root_col    <= '0;
      root_row    <= '0;
      scale       <= SCALE_W'(256);
      mask_loaded <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROOT_COL:    root_col    <= cfg_data[ROOT_W-1:0];
        CFG_ROOT_ROW:    root_row    <= cfg_data[ROOT_W-1:0];
        CFG_SCALE:       scale       <= cfg_data;
        CFG_MASK_LOADED: mask_loaded <= cfg_data[0];
      endcase
    end
  end

  assign prod_x = x_q * x_q;
  assign prod_y = y_q * y_q;
  assign trial  = sq_res + sq_bit;

  // Division operands for the current axis.
  always_comb begin
    ax      = cmd.axis ? z_q : x_q;
    t_fl    = ax >>> FRAC_BITS;
    t_tr    = t_fl + (((ax < 0) && (|ax[FRAC_BITS-1:0])) ? COORD_W'(1) : COORD_W'(0));
    n_o     = cmd.axis ? -(COORD_W+1)'(t_tr) : (COORD_W+1)'(t_tr);
    num     = ((DIV_W+1)'(n_o) <<< (SCALE_FRAC + 1)) + $signed({1'b0, (DIV_W)'(scale)});
    num_mag = (num < 0) ? -num : num;
    zmag    = (z_q < 0) ? -(COORD_W+1)'(z_q) : (COORD_W+1)'(z_q);
    rnd     = (proj_q == PROJ_ORTHO);
    if (rnd) begin
      dividend  = num_mag[DIV_W-1:0];
      neg_start = (num < 0);
      den_start = {scale, 1'b0};
    end else if (!cmd.axis) begin
      dividend  = {sq_res[COORD_W-1:0], {SCALE_FRAC{1'b0}}};
      neg_start = (x_q < 0);
      den_start = {1'b0, scale};
    end else begin
      dividend  = DIV_W'(zmag) << SCALE_FRAC;
      neg_start = (z_q > 0);
      den_start = {1'b0, scale};
    end
  end

  assign div_t = {rem, quo[DIV_W-1]};

  // Quotient to image position with fraction bits.
  always_comb begin
    q_mag   = POS_W'(quo) + ((rnd && neg && rem != '0) ? POS_W'(1) : POS_W'(0));
    q_s     = neg ? -q_mag : q_mag;
    root_ax = cmd.axis ? POS_W'(root_row) : POS_W'(root_col);
    if (rnd) begin
      pos_new = (q_s + root_ax) <<< FRAC_BITS;
    end else begin
      pos_new = q_s + (root_ax <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      proj_q <= projection;
      x_q    <= coord_x;
      y_q    <= coord_y;
      z_q    <= coord_z;
      pos_c  <= POS_W'(coord_x);
      pos_r  <= POS_W'(coord_y);
    end
    if (cmd.mul) begin
      xx <= prod_x;
      yy <= prod_y;
    end
    if (cmd.sq_init) begin
      rad    <= xx + yy;
      sq_res <= '0;
      sq_bit <= RAD_W'(1) << (RAD_W - 2);
    end
    if (cmd.sq_step) begin
      if (rad >= trial) begin
        rad    <= rad - trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_start) begin
      quo <= dividend;
      rem <= '0;
      den <= den_start;
      neg <= neg_start;
    end
    if (cmd.div_step) begin
      if (div_t >= {1'b0, den}) begin
        rem <= REM_W'(div_t - {1'b0, den});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= div_t[REM_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.pos_store) begin
      if (cmd.axis) begin
        pos_r <= pos_new;
      end else begin
        pos_c <= pos_new;
      end
    end
  end

  // Neighborhood pixel and its range check.
  always_comb begin
    nb_c    = (pos_c >>> FRAC_BITS) + POS_W'(off_val(cmd.off_c));
    nb_r    = (pos_r >>> FRAC_BITS) + POS_W'(off_val(cmd.off_r));
    nb_ok   = (nb_c >= 0) && (nb_c < POS_W'(IMAGE_SIZE)) &&
              (nb_r >= 0) && (nb_r < POS_W'(IMAGE_SIZE));
    nb_addr = ADDR_W'(ADDR_W'(nb_r[IDX_W-1:0]) * ADDR_W'(IMAGE_SIZE)
                      + ADDR_W'(nb_c[IDX_W-1:0]));
    wr_ok   = (32'(write_col) < IMAGE_SIZE) && (32'(write_row) < IMAGE_SIZE);
    wr_addr = ADDR_W'(ADDR_W'(write_row) * ADDR_W'(IMAGE_SIZE) + ADDR_W'(write_col));
  end

  assign ram_we   = cmd.wr & wr_ok;
  assign ram_addr = cmd.wr ? wr_addr : nb_addr;

  smpt_ram #(
    .WIDTH (1),
    .DEPTH (MEM_DEPTH)
  ) u_mask (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (|pixel_color),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res <= 1'b1;
    end else if (cmd.res_clr) begin
      res <= 1'b0;
    end else if (cmd.res_or) begin
      res <= res | rdata;
    end
    if (cmd.out_load) begin
      inside_res <= res;
    end
  end

  assign sts.no_mask    = ~mask_loaded;
  assign sts.scale_zero = (scale == '0);
  assign sts.nb_ok      = nb_ok;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Silhouette mask point test bench
// Loads mask pixels and queries points in every projection mode under several
// origin and scale settings, with random idling on both channels. Each result
// is checked against an in-bench model of the mask and the point mapping.
// ----------------------------------------------------------------------------
module tb_top;
  import smpt_pkg::*;

  localparam int  LIMIT   = 3000000;
  localparam int  SETTLE  = 200;
  localparam int  HOLD    = 400;
  localparam longint PIX  = 256;
  localparam longint LIM  = longint'(IMAGE_SIZE) * PIX;

  typedef struct {
    logic        kind;
    logic [1:0]  proj;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [23:0] color;
  } word_t;

  typedef enum int {MAP_PROBE, MAP_INSIDE, MAP_OUTSIDE} map_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        kind = 1'b0;
  logic [1:0]  projection = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic [9:0]  write_col = '0;
  logic [9:0]  write_row = '0;
  logic [23:0] pixel_color = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        inside_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [SCALE_W-1:0] cfg_data = '0;

  bit     mask_bits [MEM_DEPTH];
  bit     written [MEM_DEPTH];
  longint root_c, root_r;
  longint unsigned scale_q;
  bit     loaded;

  word_t  pending [$];
  bit     expected_inside [$];
  word_t  cur_word;
  int     send_idle = 0;
  int     recv_idle = 0;
  bit     hold_go = 1'b0;
  bit     held = 1'b0;
  int     hold_left = 0;
  int     errors = 0;
  int     cycles = 0;

  silhouette_mask_point_test u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_trunc(longint n);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag * PIX) / longint'(scale_q);
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic longint div_round(longint n);
    longint num, den, q;
    num = 2 * n * PIX + longint'(scale_q);
    den = 2 * longint'(scale_q);
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic map_kind_t locate(word_t w, output longint c, output longint r);
    longint x, y, z;
    x = longint'($signed(w.x));
    y = longint'($signed(w.y));
    z = longint'($signed(w.z));
    c = x;
    r = y;
    if (!loaded) return MAP_INSIDE;
    if (w.proj == PROJ_REV || w.proj == PROJ_ORTHO) begin
      if (scale_q == 0) return MAP_OUTSIDE;
      if (w.proj == PROJ_REV) begin
        c = div_trunc(longint'(isqrt(longint'(x * x) + longint'(y * y))));
        if (x < 0) c = -c;
        r = div_trunc(-z) + root_r * PIX;
        c = c + root_c * PIX;
      end else begin
        c = (div_round(x / PIX) + root_c) * PIX;
        r = (div_round(-(z / PIX)) + root_r) * PIX;
      end
    end
    return MAP_PROBE;
  endfunction

  function automatic bit predict_inside(word_t w);
    longint c, r, cc, rr;
    map_kind_t m;
    m = locate(w, c, r);
    if (m == MAP_INSIDE) return 1'b1;
    if (m == MAP_OUTSIDE) return 1'b0;
    for (int i = -1; i <= 1; i++) begin
      for (int j = -1; j <= 1; j++) begin
        cc = c + i * PIX;
        rr = r + j * PIX;
        if (cc >= 0 && cc < LIM && rr >= 0 && rr < LIM)
          if (mask_bits[(rr / PIX) * IMAGE_SIZE + cc / PIX]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void add_write(int col, int row, logic [23:0] color);
    word_t w;
    w = '{KIND_WRITE, 2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
          24'($urandom), 10'(col), 10'(row), color};
    written[row * IMAGE_SIZE + col] = 1'b1;
    pending.push_back(w);
  endfunction

  function automatic logic [23:0] rand_color();
    return ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom);
  endfunction

  // Every in-range pixel that the query will read is written first.
  function automatic void add_query(logic [1:0] proj, logic [23:0] x, logic [23:0] y,
                                    logic [23:0] z);
    word_t w;
    longint c, r, cc, rr;
    w = '{KIND_QUERY, proj, x, y, z, 10'($urandom), 10'($urandom), 24'($urandom)};
    if (locate(w, c, r) == MAP_PROBE) begin
      for (int i = -1; i <= 1; i++) begin
        for (int j = -1; j <= 1; j++) begin
          cc = c + i * PIX;
          rr = r + j * PIX;
          if (cc >= 0 && cc < LIM && rr >= 0 && rr < LIM &&
              !written[(rr / PIX) * IMAGE_SIZE + cc / PIX])
            add_write(int'(cc / PIX), int'(rr / PIX), rand_color());
        end
      end
    end
    pending.push_back(w);
  endfunction

  function automatic logic [23:0] near_image();
    return 24'($urandom_range(0, (IMAGE_SIZE + 2) * 256) - 512);
  endfunction

  function automatic logic [23:0] wide_coord();
    return 24'($signed(24'($urandom)) >>> $urandom_range(0, 23));
  endfunction

  // Queues at least n words, the writes that queries need included.
  function automatic void add_random(int n);
    logic [1:0] p;
    int start;
    start = pending.size();
    while (pending.size() - start < n) begin
      if ($urandom_range(0, 99) < 35) begin
        add_write($urandom_range(0, 1023), $urandom_range(0, 1023), rand_color());
      end else begin
        p = 2'($urandom_range(0, 3));
        if (p == PROJ_REV || p == PROJ_ORTHO)
          add_query(p, wide_coord(), wide_coord(), wide_coord());
        else if ($urandom_range(0, 3) != 0)
          add_query(p, near_image(), near_image(), 24'($urandom));
        else
          add_query(p, 24'($urandom), 24'($urandom), 24'($urandom));
      end
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [SCALE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ROOT_COL:    root_c = longint'($signed(val[ROOT_W-1:0]));
      CFG_ROOT_ROW:    root_r = longint'($signed(val[ROOT_W-1:0]));
      CFG_SCALE:       scale_q = val;
      CFG_MASK_LOADED: loaded = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || req_valid || expected_inside.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(int rc, int rr, int sc, bit ld);
    write_reg(CFG_ROOT_COL, 16'(rc));
    write_reg(CFG_ROOT_ROW, 16'(rr));
    write_reg(CFG_SCALE, 16'(sc));
    write_reg(CFG_MASK_LOADED, 16'(ld));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        if (cur_word.kind == KIND_WRITE)
          mask_bits[cur_word.row * IMAGE_SIZE + cur_word.col] = (cur_word.color != 0);
        else
          expected_inside.push_back(predict_inside(cur_word));
      end
      if (!req_valid || !req_stall) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_word = pending.pop_front();
          req_valid   <= 1'b1;
          kind        <= cur_word.kind;
          projection  <= cur_word.proj;
          coord_x     <= cur_word.x;
          coord_y     <= cur_word.y;
          coord_z     <= cur_word.z;
          write_col   <= cur_word.col;
          write_row   <= cur_word.row;
          pixel_color <= cur_word.color;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !held) begin
      held      <= 1'b1;
      hold_left <= HOLD;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    bit exp_bit;
    if (!rst && res_valid && !res_stall) begin
      if (expected_inside.size() == 0) begin
        $error("unexpected word: inside_res actual %0d", inside_res);
        errors++;
      end else begin
        exp_bit = expected_inside.pop_front();
        if (inside_res !== exp_bit) begin
          $error("inside_res expected %0d actual %0d", exp_bit, inside_res);
          errors++;
        end
      end
    end
  end

  initial begin
    root_c = 0;
    root_r = 0;
    scale_q = 256;
    loaded = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_regs(0, 0, 256, 1'b0);
    add_write(1023, 1023, 24'hFFFFFF);
    add_write(0, 0, 24'h000000);
    add_write(512, 3, 24'h000001);
    add_write(3, 512, 24'h800000);
    add_query(PROJ_DIRECT, 24'h7FFFFF, 24'h800000, 24'h000000);
    add_query(PROJ_REV, 24'h800000, 24'h7FFFFF, 24'h800000);
    add_query(PROJ_ORTHO, 24'h7FFFFF, 24'h000000, 24'h7FFFFF);
    add_query(2'd3, 24'h000000, 24'h000000, 24'h000000);
    drain();

    set_regs(0, 0, 0, 1'b1);
    add_query(PROJ_REV, 24'h000100, 24'h000100, 24'hFFFF00);
    add_query(PROJ_ORTHO, 24'h000200, 24'h000000, 24'hFFFE00);
    add_query(PROJ_DIRECT, 24'h000000, 24'h000000, 24'h000000);
    add_query(PROJ_DIRECT, 24'h03FFFF, 24'h03FFFF, 24'h000000);
    add_query(PROJ_DIRECT, 24'h000080, 24'h040000, 24'h000000);
    add_query(2'd3, 24'hFFFF80, 24'h020080, 24'h000000);
    drain();

    write_reg(CFG_SCALE, 16'd256);
    add_query(PROJ_REV, 24'hFFF000, 24'h000000, 24'hFFF000);
    add_query(PROJ_ORTHO, 24'h000180, 24'h000000, 24'hFFFE80);
    add_query(PROJ_ORTHO, 24'hFFFE80, 24'h000000, 24'h000180);
    drain();

    send_idle <= 31;
    recv_idle <= 86;
    set_regs(-2048, 2047, 1, 1'b1);
    add_random(550);
    drain();

    send_idle <= 86;
    recv_idle <= 31;
    set_regs(2047, -2048, 65535, 1'b1);
    add_random(550);
    drain();

    send_idle <= 0;
    recv_idle <= 0;
    set_regs(8, 8, $urandom_range(64, 1024), 1'b1);
    hold_go <= 1'b1;
    add_random(275);
    while (pending.size() != 0 || req_valid || expected_inside.size() != 0)
      @(posedge clk);
    add_random(275);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
